>>> sv/murmur2_hash_32_defines.svh
// ----------------------------------------------------------------------------
// murmur2_hash_32 assertion macros
// Shared property shorthands for the checker file of the hash block.
// ----------------------------------------------------------------------------
`ifndef MURMUR2_HASH_32_DEFINES_SVH
`define MURMUR2_HASH_32_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MH2_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MH2_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/mh2_pkg.sv
// ----------------------------------------------------------------------------
// mh2_pkg
// Constants and types shared by the MurmurHash2 front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package mh2_pkg;

	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int          MIX_SHIFT   = 24;
	localparam int          FIN_SHIFT_A = 13;
	localparam int          FIN_SHIFT_B = 15;
	localparam logic [31:0] SEED_RESET  = 32'd5381;

	localparam int DATA_W    = 32;
	localparam int COUNT_W   = 3;
	localparam int S_TDATA_W = 72;

	// Queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// What the back has to do with one word
	typedef enum logic [1:0] {
		KIND_SKIP,
		KIND_FULL,
		KIND_TAIL
	} kind_t;

	typedef struct packed {
		logic [DATA_W-1:0] word;  // tail words arrive already masked
		logic [DATA_W-1:0] init;  // seed ^ total length
		kind_t             kind;
		logic              first;
		logic              last;
	} item_t;

endpackage

`default_nettype wire

>>> sv/mh2_front.sv
// ----------------------------------------------------------------------------
// mh2_front
// Seed register, input word acceptance and classification into queue items.
// ----------------------------------------------------------------------------
`default_nettype none

module mh2_front
	import mh2_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [DATA_W-1:0]    cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic                 s_tlast,
	input  wire logic                 s_tuser,
	input  wire logic                 full,
	output logic                      push,
	output item_t                     push_item
);

	logic [DATA_W-1:0]  seed_q;
	logic [DATA_W-1:0]  word;
	logic [COUNT_W-1:0] count;
	logic [DATA_W-1:0]  total;
	logic [DATA_W-1:0]  mask;

	assign word  = s_tdata[DATA_W-1:0];
	assign count = s_tdata[DATA_W +: COUNT_W];
	assign total = s_tdata[DATA_W+COUNT_W +: DATA_W];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_valid) begin
			seed_q <= cfg_data;
		end
	end

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	// byte counts above four saturate to a full word
	always_comb begin
		mask           = 32'h0000_00ff;
		push_item.kind = KIND_TAIL;
		case (count)
			3'd0: begin
				push_item.kind = KIND_SKIP;
			end
			3'd1: begin
				mask = 32'h0000_00ff;
			end
			3'd2: begin
				mask = 32'h0000_ffff;
			end
			3'd3: begin
				mask = 32'h00ff_ffff;
			end
			default: begin
				mask           = 32'hffff_ffff;
				push_item.kind = KIND_FULL;
			end
		endcase
		push_item.word  = word & mask;
		push_item.init  = seed_q ^ total;
		push_item.first = s_tuser;
		push_item.last  = s_tlast;
	end

endmodule

`default_nettype wire

>>> sv/mh2_fifo.sv
// ----------------------------------------------------------------------------
// mh2_fifo
// Short item queue that decouples word acceptance from the mixing sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mh2_fifo
	import mh2_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output item_t      pop_item,
	output logic       empty
);

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);
	localparam logic [FIFO_CNT_W-1:0] CNT_FULL = FIFO_CNT_W'(FIFO_DEPTH);

	assign full     = (cnt_q == CNT_FULL);
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/mh2_back.sv
// ----------------------------------------------------------------------------
// mh2_back
// Mixing sequencer around one shared 32x32 multiplier, plus the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module mh2_back
	import mh2_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              empty,
	input  wire item_t             pop_item,
	output logic                   pop,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [DATA_W-1:0]      m_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_K1,
		ST_K2,
		ST_HM,
		ST_TAIL,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [DATA_W-1:0]   h_q;
	logic [DATA_W-1:0]   w_q;
	logic [DATA_W-1:0]   p_q;
	logic                last_q;
	logic [DATA_W-1:0]   mul_a;
	logic [DATA_W-1:0]   mul_p;
	logic [DATA_W-1:0]   h_base;

	assign pop    = (state_q == ST_IDLE) && !empty;
	assign h_base = pop_item.first ? pop_item.init : h_q;

	always_comb begin
		unique case (state_q)
			ST_K1:   mul_a = w_q;
			ST_K2:   mul_a = p_q ^ (p_q >> MIX_SHIFT);
			ST_FIN:  mul_a = h_q ^ (h_q >> FIN_SHIFT_A);
			default: mul_a = h_q;
		endcase
	end

	// keep the low half of the product only
	assign mul_p = mul_a * MIX_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			h_q      <= '0;
			w_q      <= '0;
			p_q      <= '0;
			last_q   <= 1'b0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			if (m_tvalid && m_tready && (state_q != ST_OUT)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						last_q <= pop_item.last;
						w_q    <= pop_item.word;
						case (pop_item.kind)
							KIND_FULL: begin
								h_q     <= h_base;
								state_q <= ST_K1;
							end
							KIND_TAIL: begin
								h_q     <= h_base ^ pop_item.word;
								state_q <= ST_TAIL;
							end
							default: begin
								h_q     <= h_base;
								state_q <= pop_item.last ? ST_FIN : ST_IDLE;
							end
						endcase
					end
				end
				ST_K1: begin
					p_q     <= mul_p;
					state_q <= ST_K2;
				end
				ST_K2: begin
					p_q     <= mul_p;
					state_q <= ST_HM;
				end
				ST_HM: begin
					h_q     <= mul_p ^ p_q;
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_TAIL: begin
					h_q     <= mul_p;
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					p_q     <= mul_p;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tdata  <= p_q ^ (p_q >> FIN_SHIFT_B);
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/murmur2_hash_32.sv
// ----------------------------------------------------------------------------
// murmur2_hash_32
// Streaming 32-bit MurmurHash2 over little-endian message words.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   cfg       in         cfg_valid/ready     cfg_data: hash seed
//   s_axis    in         s_tvalid/tready     tdata word, tlast, tuser = first
//   m_axis    out        m_tvalid/tready     tdata: finished hash
//
// In the back sequencer a full word passes K1, K2 and HM, a one to three byte
// word TAIL, an empty word only IDLE; a last word adds FIN for the avalanche
// and OUT for the output load. Every multiply uses the one shared multiplier.
// Reset (arst_n low) loads the seed with 5381 and clears the running hash.
// A two-entry queue lets the input keep taking words while the sequencer
// works, and the output register lets the sequencer go on while a hash waits.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur2_hash_32
	import mh2_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// seed write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [DATA_W-1:0]    cfg_data,
	// input words
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// [31:0] data_word, [34:32] byte_count, [66:35] total_length, [71:67] zero
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic                 s_tlast,   // last_word
	input  wire logic                 s_tuser,   // [0] first_word
	// hash results
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [31:0] hash_value
	output logic [DATA_W-1:0]         m_tdata
);

	item_t push_item;
	item_t pop_item;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;

	// accept and classify: seed ^ length, masking, byte count saturation
	mh2_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.full      (full),
		.push      (push),
		.push_item (push_item)
	);

	// hold classified words until the sequencer is free
	mh2_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	// mix, finalize and drive the result word
	mh2_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop_item (pop_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

>>> sv/murmur2_hash_32_checker.sv
// ----------------------------------------------------------------------------
// murmur2_hash_32_checker
// Port-level checks on the hash block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "murmur2_hash_32_defines.svh"

module murmur2_hash_32_checker
	import mh2_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 cfg_valid,
	input wire logic                 cfg_ready,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [DATA_W-1:0]    m_tdata
);

	`MH2_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "hash word dropped")
	`MH2_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "hash word moved")
	`MH2_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "seed write not taken")
	`MH2_ASSERT_SAME(a_ready_fall, $fell(s_tready), $past(s_tvalid && s_tready), "full too early")

endmodule

bind murmur2_hash_32 murmur2_hash_32_checker u_checker (.*);

`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: murmur2_hash_32
// Drives messages of little-endian words through the hash block and checks
// every finished hash against a running MurmurHash2 predictor. A short table
// of corner words comes first. Random well-formed, broken and noise messages
// follow under several seeds, with random idling on both streams, one long
// output hold-off and one stretch with no idling.
// ----------------------------------------------------------------------------

module testbench;
	import mh2_pkg::*;

	localparam logic [2:0] FULL_WORD      = 3'd4;
	localparam int         IDLE_PCT       = 30;
	localparam int         HOLD_CYCLES    = 300;
	localparam int         SETTLE_CYCLES  = 40;
	localparam int         WORDS_PER_SEED = 85;
	localparam int         NUM_SEEDS      = 6;
	localparam int         NUM_ROWS       = 21;

	// One directed word; the hash is typed in only where it is obvious.
	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  nbytes;
		logic [31:0] total;
		logic        first;
		logic        last;
		logic        typed;
		logic [31:0] hash;
	} word_row_t;

	// Corner words. An empty message with no first word right after reset
	// hashes the cleared running value, and the avalanche of zero is zero.
	word_row_t directed_rows [0:NUM_ROWS-1] = '{
		'{32'h0000_0000, 3'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0000_0000},
		'{32'hFFFF_FFFF, 3'd0, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'h0},
		'{32'hFFFF_FFFF, 3'd4, 32'h0000_0004, 1'b1, 1'b1, 1'b0, 32'h0},
		'{32'h0000_0000, 3'd4, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0},
		'{32'hFFFF_FFFF, 3'd4, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'hA5C3_3C5A, 3'd3, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0},
		'{32'h1234_5678, 3'd1, 32'h0000_0001, 1'b1, 1'b1, 1'b0, 32'h0},
		'{32'h1234_5678, 3'd2, 32'h0000_0002, 1'b1, 1'b1, 1'b0, 32'h0},
		'{32'h1234_5678, 3'd3, 32'h0000_0003, 1'b1, 1'b1, 1'b0, 32'h0},
		'{32'hDEAD_BEEF, 3'd5, 32'h0000_0004, 1'b1, 1'b1, 1'b0, 32'h0},
		'{32'hDEAD_BEEF, 3'd6, 32'h0000_0004, 1'b1, 1'b1, 1'b0, 32'h0},
		'{32'hDEAD_BEEF, 3'd7, 32'h0000_0004, 1'b1, 1'b1, 1'b0, 32'h0},
		'{32'hCAFE_F00D, 3'd2, 32'h0000_000A, 1'b1, 1'b0, 1'b0, 32'h0},
		'{32'h0BAD_C0DE, 3'd4, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h5555_5555, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'hAAAA_AAAA, 3'd4, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0},
		'{32'h8000_0001, 3'd4, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 32'h0},
		'{32'h7FFF_FFFE, 3'd4, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
		'{32'h1357_9BDF, 3'd4, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'h0},
		'{32'h0246_8ACE, 3'd4, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0},
		'{32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 32'h0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [DATA_W-1:0]    cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	// [31:0] data_word, [34:32] byte_count, [66:35] total_length, [71:67] zero
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tlast;   // last_word
	logic                 s_tuser;   // [0] first_word
	logic                 m_tvalid;
	logic                 m_tready;
	// [31:0] hash_value
	logic [DATA_W-1:0]    m_tdata;

	// Predictor state: seed register and pre-avalanche running hash.
	logic [31:0] model_seed;
	logic [31:0] model_running;
	logic [31:0] expected_hashes [$];

	int unsigned mismatches  = 0;
	int unsigned words_taken = 0;
	bit          steady      = 1'b0;  // no idling on either stream
	bit          hold_output = 1'b0;  // ask the sink for a long hold-off

	murmur2_hash_32 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Fold one word into the running hash; return 1 with the finished hash
	// when the word closes the message. Counts above four act as four.
	function automatic bit advance_hash(input logic [31:0] data, input logic [2:0] nbytes,
			input logic [31:0] total, input logic first, input logic last,
			output logic [31:0] hash);
		logic [31:0] h;
		logic [31:0] k;
		logic [31:0] mask;
		h = first ? (model_seed ^ total) : model_running;
		if (nbytes >= FULL_WORD) begin
			k = data * MIX_MUL;
			k = k ^ (k >> MIX_SHIFT);
			k = k * MIX_MUL;
			h = (h * MIX_MUL) ^ k;
		end else if (nbytes != 3'd0) begin
			mask = (nbytes == 3'd3) ? 32'h00FF_FFFF :
			       (nbytes == 3'd2) ? 32'h0000_FFFF : 32'h0000_00FF;
			h = (h ^ (data & mask)) * MIX_MUL;
		end
		model_running = h;
		h = h ^ (h >> FIN_SHIFT_A);
		h = h * MIX_MUL;
		h = h ^ (h >> FIN_SHIFT_B);
		hash = h;
		return last;
	endfunction

	// Offer one word, hold it until taken, then predict. A typed hash takes
	// the place of the predicted one.
	task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
			input logic [31:0] total, input logic first, input logic last,
			input logic typed = 1'b0, input logic [31:0] typed_hash = 32'h0);
		logic [31:0] hash;
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, total, nbytes, data};
		s_tlast  <= last;
		s_tuser  <= first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (advance_hash(data, nbytes, total, first, last, hash))
			expected_hashes.push_back(typed ? typed_hash : hash);
		if (nbytes != 3'd0 || first || last)
			words_taken++;
	endtask

	// Drop the input and wait for every pending hash, then realign to the clock.
	task automatic drain();
		s_tvalid <= 1'b0;
		wait (expected_hashes.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] seed);
		cfg_valid <= 1'b1;
		cfg_data  <= seed;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		model_seed = seed;
		cfg_valid <= 1'b0;
	endtask

	// One message of random bytes. A broken one loses its first-word or its
	// last-word flag, or gets a partial word before its last word.
	task automatic send_message(input bit broken);
		int unsigned len;
		int unsigned nwords;
		int unsigned flaw;
		int unsigned cut;
		logic [31:0] total;
		logic [2:0]  nbytes;
		len    = ($urandom_range(15) == 0) ? $urandom_range(200) : $urandom_range(24);
		total  = ($urandom_range(9) == 0) ? $urandom : len;
		nwords = (len == 0) ? 1 : (len + 3) / 4;
		flaw   = broken ? $urandom_range(3, 1) : 0;
		cut    = $urandom_range(nwords - 1);
		for (int unsigned i = 0; i < nwords; i++) begin
			if (len == 0)
				nbytes = 3'd0;
			else if (len - 4 * i >= 4)
				nbytes = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : FULL_WORD;
			else
				nbytes = 3'(len - 4 * i);
			if (flaw == 3 && i == cut && i + 1 < nwords)
				nbytes = 3'($urandom_range(3, 1));
			send_word($urandom, nbytes, total, i == 0 && flaw != 1,
			          i + 1 == nwords && flaw != 2);
		end
	endtask

	// Sink: random back-pressure, a long hold-off on request, none when steady.
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_output) begin
				hold_output = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Compare each hash word taken from the block with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_hashes.size() == 0)
				flag_mismatch($sformatf("unexpected hash %08h", m_tdata));
			else if (m_tdata !== expected_hashes[0])
				flag_mismatch($sformatf("hash_value %08h, predicted %08h",
				                        m_tdata, expected_hashes.pop_front()));
			else
				void'(expected_hashes.pop_front());
		end
	end

	// Stimulus: reset, corner table, then random messages under each seed.
	initial begin
		int unsigned start;
		int unsigned pick;
		logic [31:0] seed;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		s_tuser       = 1'b0;
		model_seed    = SEED_RESET;
		model_running = 32'h0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].data, directed_rows[i].nbytes, directed_rows[i].total,
			          directed_rows[i].first, directed_rows[i].last,
			          directed_rows[i].typed, directed_rows[i].hash);

		for (int phase = 0; phase < NUM_SEEDS; phase++) begin
			if (phase > 0) begin
				// Let words that emit nothing clear the block before the write.
				drain();
				repeat (SETTLE_CYCLES) @(posedge clk);
				case (phase)
					1: seed = 32'h0000_0000;
					2: seed = 32'hFFFF_FFFF;
					4: seed = 32'h8000_0000;
					default: seed = $urandom;
				endcase
				write_seed(seed);
			end
			if (phase == 2) begin
				// Hold the output off and keep offering until the input stalls,
				// then pause until every hash is out.
				hold_output = 1'b1;
				repeat (12) send_message(1'b0);
				drain();
			end
			steady = (phase == 3);
			start  = words_taken;
			while (words_taken - start < WORDS_PER_SEED) begin
				pick = $urandom_range(99);
				if (pick < 80)
					send_message(1'b0);
				else if (pick < 92)
					send_message(1'b1);
				else
					send_word($urandom, 3'($urandom_range(7)), $urandom,
					          1'($urandom_range(1)), 1'($urandom_range(1)));
			end
			steady = 1'b0;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
